>>> hw/rtl/lgdc_pkg.sv
`default_nettype none
package lgdc_pkg;

	// operand width of the arithmetic, default
	localparam int VALUE_BITS_DEF = 31;
	// fixed field widths
	localparam int CMD_W = 2;
	localparam int VAL_W = 31;
	localparam int CNT_W = 11;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;
	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_DIVISOR  = 2'd0,
		CMD_MULTIPLE = 2'd1,
		CMD_COMPUTE  = 2'd2,
		CMD_UNUSED   = 2'd3
	} cmd_code_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [VAL_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] divisor_count;
		logic             no_multiples;
	} res_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/lgdc_queue.sv
`default_nettype none
module lgdc_queue import lgdc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  cmd_item_t      push_item,
	input  wire logic      pop,
	output cmd_item_t      head,
	output q_stat_t        stat
);
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cmd_item_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [NW-1:0]   num_q;
	logic            do_push;
	logic            do_pop;

	assign stat.full  = (num_q == NW'(QUEUE_DEPTH));
	assign stat.empty = (num_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			num_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				num_q <= num_q + 1'b1;
			end else if (do_pop && !do_push) begin
				num_q <= num_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lgdc_div.sv
`default_nettype none
module lgdc_div import lgdc_pkg::*; #(
	parameter int W = VALUE_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quot,
	output logic [W-1:0]      rem
);
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;
	logic [CW-1:0] step_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic          ge;
	logic [W:0]    diff;

	// one restoring step per cycle
	assign shifted = {rem_q, quo_q[W-1]};
	assign ge      = (shifted >= {1'b0, div_q});
	assign diff    = shifted - {1'b0, div_q};

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				div_q  <= divisor;
				step_q <= CW'(W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[W-1:0] : shifted[W-1:0];
				quo_q  <= {quo_q[W-2:0], ge};
				step_q <= step_q - 1'b1;
				if (step_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lgdc_back.sv
`default_nettype none
module lgdc_back import lgdc_pkg::*; #(
	parameter int W = VALUE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  cmd_item_t  q_item,
	output logic       q_pop,
	output logic       res_valid,
	input  wire logic  res_ready,
	output res_item_t  res
);
	localparam int CW = $clog2(W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUC,
		ST_LDIV,
		ST_MUL,
		ST_MOD,
		ST_CNT,
		ST_EMIT
	} state_t;

	state_t         state_q;
	logic [W-1:0]   lcm_q;
	logic           ovf_q;
	logic [W-1:0]   gcd_q;
	logic           have_q;
	logic [W-1:0]   v_q;
	logic [W-1:0]   b_q;
	logic           mode_lcm_q;
	logic [W-1:0]   t_q;
	logic [W-1:0]   acc_q;
	logic [CW-1:0]  mul_i_q;
	logic [W-1:0]   quo_val_q;
	logic [W-1:0]   d_q;
	logic [CNT_W-1:0] cnt_q;
	logic           empty_q;
	logic           out_valid_q;
	res_item_t      out_q;

	logic [W-1:0]   v_in;
	logic           div_start;
	logic [W-1:0]   div_n;
	logic [W-1:0]   div_d;
	logic           div_done;
	logic [W-1:0]   div_quot;
	logic [W-1:0]   div_rem;
	logic [W+1:0]   mul_sum;
	logic [CNT_W:0] cnt_sum;
	logic           out_free;

	assign v_in      = W'(q_item.value);
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign res_valid = out_valid_q;
	assign res       = out_q;
	assign out_free  = !out_valid_q || res_ready;

	// serial shift-add product, msb of t first
	assign mul_sum = {1'b0, acc_q, 1'b0} + (W+2)'(t_q[W-1] ? v_q : '0);
	// divisor count step with saturation
	assign cnt_sum = {1'b0, cnt_q} + ((div_quot != d_q) ? (CNT_W+1)'(2) : (CNT_W+1)'(1));

	// shared divider requests
	always_comb begin
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_item.command)
						CMD_DIVISOR: begin
							div_start = !ovf_q;
							div_n     = lcm_q;
							div_d     = v_in;
						end
						CMD_MULTIPLE: begin
							div_start = have_q;
							div_n     = gcd_q;
							div_d     = v_in;
						end
						CMD_COMPUTE: begin
							div_start = have_q && !ovf_q;
							div_n     = gcd_q;
							div_d     = lcm_q;
						end
						default: ;
					endcase
				end
			end
			ST_EUC: begin
				if (div_done && div_rem != '0) begin
					div_start = 1'b1;
					div_n     = b_q;
					div_d     = div_rem;
				end else if (div_done && mode_lcm_q) begin
					div_start = 1'b1;
					div_n     = lcm_q;
					div_d     = b_q;
				end
			end
			ST_MOD: begin
				if (div_done && div_rem == '0) begin
					div_start = 1'b1;
					div_n     = div_quot;
					div_d     = W'(2);
				end
			end
			ST_CNT: begin
				if (div_done && div_quot >= d_q) begin
					div_start = 1'b1;
					div_n     = quo_val_q;
					div_d     = d_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	lgdc_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// sequencer, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lcm_q       <= W'(1);
			ovf_q       <= 1'b0;
			gcd_q       <= '0;
			have_q      <= 1'b0;
			v_q         <= '0;
			b_q         <= '0;
			mode_lcm_q  <= 1'b0;
			t_q         <= '0;
			acc_q       <= '0;
			mul_i_q     <= '0;
			quo_val_q   <= '0;
			d_q         <= '0;
			cnt_q       <= '0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (res_valid && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						v_q <= v_in;
						b_q <= v_in;
						case (q_item.command)
							CMD_DIVISOR: begin
								mode_lcm_q <= 1'b1;
								if (!ovf_q) begin
									state_q <= ST_EUC;
								end
							end
							CMD_MULTIPLE: begin
								mode_lcm_q <= 1'b0;
								if (!have_q) begin
									gcd_q  <= v_in;
									have_q <= 1'b1;
								end else begin
									state_q <= ST_EUC;
								end
							end
							CMD_COMPUTE: begin
								cnt_q   <= '0;
								empty_q <= !have_q;
								if (have_q && !ovf_q) begin
									state_q <= ST_MOD;
								end else begin
									state_q <= ST_EMIT;
								end
							end
							default: ;
						endcase
					end
				end
				ST_EUC: begin
					if (div_done) begin
						if (div_rem != '0) begin
							b_q <= div_rem;
						end else if (mode_lcm_q) begin
							state_q <= ST_LDIV;
						end else begin
							gcd_q   <= b_q;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_LDIV: begin
					if (div_done) begin
						t_q     <= div_quot;
						acc_q   <= '0;
						mul_i_q <= CW'(W);
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_sum[W+1:W] != 2'b00) begin
						ovf_q   <= 1'b1;
						state_q <= ST_IDLE;
					end else if (mul_i_q == CW'(1)) begin
						lcm_q   <= mul_sum[W-1:0];
						state_q <= ST_IDLE;
					end else begin
						acc_q   <= mul_sum[W-1:0];
						t_q     <= {t_q[W-2:0], 1'b0};
						mul_i_q <= mul_i_q - 1'b1;
					end
				end
				ST_MOD: begin
					if (div_done) begin
						if (div_rem != '0) begin
							state_q <= ST_EMIT;
						end else begin
							quo_val_q <= div_quot;
							cnt_q     <= (div_quot > W'(1)) ? CNT_W'(2) : CNT_W'(1);
							d_q       <= W'(2);
							state_q   <= ST_CNT;
						end
					end
				end
				ST_CNT: begin
					if (div_done) begin
						if (div_quot < d_q) begin
							state_q <= ST_EMIT;
						end else begin
							if (div_rem == '0) begin
								cnt_q <= cnt_sum[CNT_W] ? COUNT_MAX : cnt_sum[CNT_W-1:0];
							end
							d_q <= d_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.divisor_count <= cnt_q;
						out_q.no_multiples  <= empty_q;
						lcm_q               <= W'(1);
						ovf_q               <= 1'b0;
						gcd_q               <= '0;
						have_q              <= 1'b0;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lcm_gcd_quotient_divisor_counter_core.sv
// Divisor/multiple accumulator with divisor counting of G/L.
// Input channel cmd_valid/cmd_ready/cmd carries a command and a value:
// add divisor (running LCM L), add multiple (running GCD G), or compute.
// Output channel res_valid/res_ready/res carries one result per compute:
// the divisor count of G/L (0 if L does not divide G or L overflowed) and
// a flag for a compute with no multiple loaded. Compute clears the state.
// Items are classified on entry; unused codes are dropped, as are divisor
// and multiple items with a zero value; the rest wait in a two-entry queue
// in front of a sequencer. Every division runs on one shared restoring
// divider; the multiply is a serial shift-add in the sequencer. A divisor
// item costs its Euclid steps plus one division plus a multiply; a multiple
// item costs its Euclid steps; a compute costs (1 + sqrt(G/L)) divisions,
// so it grows with the square root of the quotient.
// After reset L is 1, G is empty and no overflow is pending.
// If the receiver stalls, the result stays in the output register; the
// sequencer keeps working and only blocks on its next compute, while the
// queue keeps taking items until it is full.
`default_nettype none
module lcm_gcd_quotient_divisor_counter_core import lgdc_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	output logic       cmd_ready,
	input  cmd_item_t  cmd,
	output logic       res_valid,
	input  wire logic  res_ready,
	output res_item_t  res
);
	logic            keep;
	logic            q_push;
	logic            q_pop;
	cmd_item_t       q_head;
	q_stat_t         q_stat;
	logic [VALUE_BITS-1:0] val_w;

	// front: drop unused codes and zero operands
	assign val_w     = VALUE_BITS'(cmd.value);
	assign keep      = (cmd.command == CMD_COMPUTE) ||
	                   (((cmd.command == CMD_DIVISOR) || (cmd.command == CMD_MULTIPLE)) &&
	                    (val_w != '0));
	assign cmd_ready = !q_stat.full;
	assign q_push    = cmd_valid && cmd_ready && keep;

	lgdc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (cmd),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	lgdc_back #(.W(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_stat.empty),
		.q_item    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// back never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty) else $error("pop from empty queue");

	// unused command code never enters the queue
	a_drop_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd.command == CMD_UNUSED) |-> !q_push)
		else $error("unused command queued");

	// queue status is consistent
	a_stat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty)) else $error("queue full and empty");

endmodule
`default_nettype wire

>>> tb/tb_lcm_gcd_quotient_divisor_counter_core.sv
`default_nettype none
module tb_lcm_gcd_quotient_divisor_counter_core;
	import lgdc_pkg::*;

	localparam longint unsigned VMAX = (64'd1 << 31) - 1;
	// quotients above this make the compute too slow for the run
	localparam longint unsigned QUOT_CAP = 64'd1 << 20;

	// running lcm/gcd tracker and store of expected divisor counts
	class divcount_board;
		longint unsigned lcm_acc;
		longint unsigned gcd_acc;
		bit lcm_ovf;
		bit have_mult;
		res_item_t exp_q[$];
		int errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			lcm_acc = 1;
			gcd_acc = 0;
			lcm_ovf = 0;
			have_mult = 0;
		endfunction

		function longint unsigned euclid(longint unsigned a, longint unsigned b);
			longint unsigned r;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			return a;
		endfunction

		function longint unsigned num_divisors(longint unsigned q);
			longint unsigned n;
			longint unsigned d;
			n = (q > 1) ? 2 : 1;
			for (d = 2; d <= q / d; d++) begin
				if (q % d == 0)
					n += (q / d != d) ? 2 : 1;
			end
			return n;
		endfunction

		// accepted command transfer
		function void note(cmd_item_t it);
			longint unsigned v;
			longint unsigned t;
			res_item_t r;
			v = it.value;
			case (cmd_code_t'(it.command))
				CMD_DIVISOR: begin
					if (v != 0 && !lcm_ovf) begin
						t = lcm_acc / euclid(lcm_acc, v);
						if (t > VMAX / v)
							lcm_ovf = 1;
						else
							lcm_acc = t * v;
					end
				end
				CMD_MULTIPLE: begin
					if (v != 0) begin
						gcd_acc = have_mult ? euclid(gcd_acc, v) : v;
						have_mult = 1;
					end
				end
				CMD_COMPUTE: begin
					r = '0;
					if (!have_mult)
						r.no_multiples = 1'b1;
					else if (!lcm_ovf && gcd_acc % lcm_acc == 0) begin
						t = num_divisors(gcd_acc / lcm_acc);
						r.divisor_count = (t > COUNT_MAX) ? COUNT_MAX : t[CNT_W-1:0];
					end
					exp_q.push_back(r);
					clear();
				end
				default: ;
			endcase
		endfunction

		// accepted result transfer
		function void check(res_item_t got);
			res_item_t e;
			if (exp_q.size() == 0) begin
				$display("%0t: unexpected result count=%0d empty=%0d", $time,
					got.divisor_count, got.no_multiples);
				errors++;
				return;
			end
			e = exp_q.pop_front();
			if (got.divisor_count !== e.divisor_count) begin
				$display("%0t: divisor_count expected %0d actual %0d", $time,
					e.divisor_count, got.divisor_count);
				errors++;
			end
			if (got.no_multiples !== e.no_multiples) begin
				$display("%0t: no_multiples expected %0d actual %0d", $time,
					e.no_multiples, got.no_multiples);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cmd_valid = 0;
	logic cmd_ready;
	cmd_item_t cmd = '0;
	logic res_valid;
	logic res_ready = 0;
	res_item_t res;

	divcount_board board = new();
	int tx_idle = 15;
	int rx_idle = 53;
	bit hold_go = 0;
	int hold_left = 0;
	int sent = 0;

	lcm_gcd_quotient_divisor_counter_core uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always #6 clk = ~clk;

	// result side: check transfers and pick next ready
	always @(posedge clk) begin
		if (res_valid && res_ready)
			board.check(res);
		if (hold_go) begin
			hold_left = 3000;
			hold_go = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else
			res_ready <= ($urandom_range(99) >= rx_idle);
	end

	task automatic push_cmd(cmd_code_t c, logic [VAL_W-1:0] v);
		cmd_item_t it;
		it.command = c;
		it.value = v;
		if ($urandom_range(99) < tx_idle) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		board.note(it);
		sent++;
	endtask

	// shrink G first when the quotient would take too long to count
	task automatic compute_cmd();
		if (board.have_mult && !board.lcm_ovf && board.gcd_acc % board.lcm_acc == 0 &&
				board.gcd_acc / board.lcm_acc > QUOT_CAP)
			push_cmd(CMD_MULTIPLE, VAL_W'($urandom_range(1, 1000)));
		push_cmd(CMD_COMPUTE, VAL_W'($urandom));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (board.exp_q.size() != 0) @(posedge clk);
	endtask

	// divisors of L, then multiples of L with a small quotient, then compute
	task automatic good_seq();
		longint unsigned q;
		longint unsigned l;
		int j;
		q = ($urandom_range(9) == 0) ? $urandom_range(1, QUOT_CAP) : $urandom_range(1, 4096);
		l = $urandom_range(1, VMAX / q);
		for (j = 2; j < 40; j++)
			if (l % j == 0 && $urandom_range(2) == 0)
				push_cmd(CMD_DIVISOR, VAL_W'(j));
		push_cmd(CMD_DIVISOR, VAL_W'(l));
		push_cmd(CMD_MULTIPLE, VAL_W'(l * q));
		if ($urandom_range(1))
			push_cmd(CMD_MULTIPLE, VAL_W'(l * q * $urandom_range(1, VMAX / (l * q))));
		if ($urandom_range(4) == 0)
			push_cmd(CMD_MULTIPLE, VAL_W'($urandom_range(1, VMAX)));
		if ($urandom_range(4) == 0)
			push_cmd(CMD_DIVISOR, VAL_W'($urandom_range(1, 5000)));
		compute_cmd();
	endtask

	task automatic noise_seq();
		int n;
		int w;
		n = $urandom_range(1, 6);
		repeat (n) begin
			w = $urandom_range(0, 31);
			push_cmd(cmd_code_t'($urandom_range(0, 3)),
				VAL_W'($urandom & ((64'd1 << w) - 1)));
		end
		compute_cmd();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty compute, unused code, zero value
		push_cmd(CMD_COMPUTE, '1);
		push_cmd(CMD_UNUSED, 31'd5);
		push_cmd(CMD_MULTIPLE, 31'd0);
		push_cmd(CMD_DIVISOR, 31'd0);
		push_cmd(CMD_COMPUTE, '0);
		// no divisor: L stays 1, G = 36
		push_cmd(CMD_MULTIPLE, 31'd36);
		compute_cmd();
		// G = 1
		push_cmd(CMD_MULTIPLE, 31'd1);
		push_cmd(CMD_DIVISOR, 31'd1);
		compute_cmd();
		// full-scale values, reduced to a small gcd
		push_cmd(CMD_MULTIPLE, '1);
		push_cmd(CMD_MULTIPLE, 31'd2);
		push_cmd(CMD_DIVISOR, '1);
		compute_cmd();
		// lcm overflow, later divisors ignored
		push_cmd(CMD_DIVISOR, '1);
		push_cmd(CMD_DIVISOR, 31'h4000_0000);
		push_cmd(CMD_DIVISOR, 31'd3);
		push_cmd(CMD_MULTIPLE, 31'd6);
		compute_cmd();
		// L does not divide G
		push_cmd(CMD_DIVISOR, 31'd7);
		push_cmd(CMD_MULTIPLE, 31'd12);
		compute_cmd();
		// L bigger than G
		push_cmd(CMD_DIVISOR, 31'd100);
		push_cmd(CMD_MULTIPLE, 31'd50);
		compute_cmd();

		// long receiver stall while commands keep coming
		hold_go = 1;
		repeat (8) compute_cmd();
		drain();

		while (sent < 420) begin
			if (sent > 150 && tx_idle == 15) begin
				drain();
				tx_idle = 53;
				rx_idle = 15;
			end else if (sent > 290 && tx_idle == 53) begin
				drain();
				tx_idle = 0;
				rx_idle = 0;
			end
			if ($urandom_range(3) == 0)
				noise_seq();
			else
				good_seq();
		end
		drain();
		repeat (200) @(posedge clk);
		if (board.errors == 0 && board.exp_q.size() == 0)
			$display("lcm_gcd_quotient_divisor_counter_core regression: pass");
		else
			$display("lcm_gcd_quotient_divisor_counter_core regression: fail");
		$finish;
	end

	// watchdog
	initial begin
		#(12 * 40_000_000);
		$display("lcm_gcd_quotient_divisor_counter_core regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
